FILE: rtl/core/bbd_pkg.sv
// Shared types and constants of the bilinear Bayer demosaic block.
`timescale 1ns / 1ps
package bbd_pkg;

  localparam int unsigned CfgWidth   = 12;
  localparam int unsigned PixWidth   = 8;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueCntW  = 3;

  localparam logic [CfgWidth-1:0] WidthReset  = 12'd640;
  localparam logic [CfgWidth-1:0] HeightReset = 12'd480;

  // register indexes on the configuration port
  localparam logic RegWidth  = 1'b0;
  localparam logic RegHeight = 1'b1;

  // input operation codes
  localparam logic OpSample = 1'b0;
  localparam logic OpFlush  = 1'b1;

  // one window position handed from the front to the back
  typedef struct packed {
    logic [8:0][PixWidth-1:0] win;
    logic                     has_l;
    logic                     has_r;
    logic                     has_u;
    logic                     has_d;
    logic                     x_odd;
    logic                     y_odd;
    logic                     eor;
    logic                     eof;
  } bbd_job_t;

endpackage

FILE: rtl/core/bbd_stream_if.sv
// Valid/ready stream interfaces for the raw input and the RGB output channels.
`timescale 1ns / 1ps
interface bbd_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] raw_sample;

  modport source (output valid, output op, output raw_sample, input ready);
  modport sink   (input valid, input op, input raw_sample, output ready);
endinterface

interface bbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       end_of_row;
  logic       end_of_frame;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output end_of_row, output end_of_frame, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input end_of_row, input end_of_frame, output ready);
endinterface

FILE: rtl/core/bbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module bbd_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/core/bbd_front.sv
// Front end: configuration, raster counters, line stores and the 3x3 window.
`timescale 1ns / 1ps
module bbd_front #(
  parameter int unsigned MaxWidth = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bbd_pkg::CfgWidth-1:0] cfg_data_i,
  bbd_in_if.sink                       in_if,
  input  logic [bbd_pkg::QueueCntW-1:0] q_count_i,
  output logic                         push_o,
  output bbd_pkg::bbd_job_t            job_o
);

  localparam int unsigned CW = $clog2(MaxWidth);
  localparam int unsigned WW = CW + 1;
  localparam int unsigned PW = bbd_pkg::PixWidth;

  logic [bbd_pkg::CfgWidth-1:0] width_q, height_q;
  logic [15:0]                  wx;
  logic [WW-1:0]                eff_w;
  logic [11:0]                  eff_h;

  logic [CW-1:0] in_col_q, out_col_q;
  logic [12:0]   in_row_q;
  logic [11:0]   out_row_q;

  logic          accept, frame_in, step, ready_pos, col_last;
  logic [PW-1:0] smp;
  logic          has_l, has_r, has_u, has_d, last;

  logic          s2_v_q, s2_ready_q;
  logic [PW-1:0] s2_smp_q;
  logic [CW-1:0] s2_addr_q;
  logic          s2_l_q, s2_r_q, s2_u_q, s2_d_q, s2_xo_q, s2_yo_q, s2_eor_q, s2_eof_q;

  logic [2*PW-1:0]      rdata;
  logic [8:0][PW-1:0]   win_q, win_d;

  // geometry clamp
  always_comb begin
    wx = 16'(width_q);
    if (wx < 16'd2) begin
      eff_w = WW'(2);
    end else if (wx > 16'(MaxWidth)) begin
      eff_w = WW'(MaxWidth);
    end else begin
      eff_w = wx[WW-1:0];
    end
    eff_h = (height_q < 12'd2) ? 12'd2 : height_q;
  end

  assign in_if.ready = ({1'b0, q_count_i} + {3'b0, s2_v_q}) < 4'(bbd_pkg::QueueDepth);
  assign accept      = in_if.valid && in_if.ready;
  assign frame_in    = in_row_q < {1'b0, eff_h};
  // early flush ticks are dropped without touching any state
  assign step        = accept && !(frame_in && (in_if.op == bbd_pkg::OpFlush));
  assign smp         = frame_in ? in_if.raw_sample : '0;
  assign ready_pos   = (in_row_q >= 13'd2) || ((in_row_q == 13'd1) && (in_col_q != '0));
  assign col_last    = ({1'b0, in_col_q} + WW'(1)) == eff_w;

  assign has_l = out_col_q != '0;
  assign has_r = ({1'b0, out_col_q} + WW'(1)) != eff_w;
  assign has_u = out_row_q != '0;
  assign has_d = (out_row_q + 12'd1) != eff_h;
  assign last  = !has_r && !has_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q   <= bbd_pkg::WidthReset;
      height_q  <= bbd_pkg::HeightReset;
      in_col_q  <= '0;
      in_row_q  <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      s2_v_q    <= 1'b0;
    end else begin
      s2_v_q <= step;
      if (cfg_we_i) begin
        if (cfg_idx_i == bbd_pkg::RegWidth) begin
          width_q <= cfg_data_i;
        end else begin
          height_q <= cfg_data_i;
        end
        in_col_q  <= '0;
        in_row_q  <= '0;
        out_col_q <= '0;
        out_row_q <= '0;
      end else if (step) begin
        if (ready_pos && last) begin
          in_col_q  <= '0;
          in_row_q  <= '0;
          out_col_q <= '0;
          out_row_q <= '0;
        end else begin
          if (col_last) begin
            in_col_q <= '0;
            in_row_q <= in_row_q + 13'd1;
          end else begin
            in_col_q <= in_col_q + CW'(1);
          end
          if (ready_pos) begin
            if (!has_r) begin
              out_col_q <= '0;
              out_row_q <= out_row_q + 12'd1;
            end else begin
              out_col_q <= out_col_q + CW'(1);
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      s2_ready_q <= ready_pos;
      s2_smp_q   <= smp;
      s2_addr_q  <= in_col_q;
      s2_l_q     <= has_l;
      s2_r_q     <= has_r;
      s2_u_q     <= has_u;
      s2_d_q     <= has_d;
      s2_xo_q    <= out_col_q[0];
      s2_yo_q    <= out_row_q[0];
      s2_eor_q   <= !has_r;
      s2_eof_q   <= last;
    end
    if (s2_v_q) begin
      win_q <= win_d;
    end
  end

  // upper store in the high byte, middle store in the low byte
  bbd_ram #(
    .Width (2 * PW),
    .Depth (MaxWidth)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (s2_v_q),
    .waddr_i (s2_addr_q),
    .wdata_i ({rdata[PW-1:0], s2_smp_q}),
    .re_i    (step),
    .raddr_i (in_col_q),
    .rdata_o (rdata)
  );

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      win_d[k*3]   = win_q[k*3+1];
      win_d[k*3+1] = win_q[k*3+2];
    end
    win_d[2] = rdata[2*PW-1:PW];
    win_d[5] = rdata[PW-1:0];
    win_d[8] = s2_smp_q;
  end

  assign push_o      = s2_v_q && s2_ready_q;
  assign job_o.win   = win_d;
  assign job_o.has_l = s2_l_q;
  assign job_o.has_r = s2_r_q;
  assign job_o.has_u = s2_u_q;
  assign job_o.has_d = s2_d_q;
  assign job_o.x_odd = s2_xo_q;
  assign job_o.y_odd = s2_yo_q;
  assign job_o.eor   = s2_eor_q;
  assign job_o.eof   = s2_eof_q;

endmodule

FILE: rtl/core/bbd_fifo.sv
// Short queue of window positions between the front and the back.
`timescale 1ns / 1ps
module bbd_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  bbd_pkg::bbd_job_t             job_i,
  input  logic                          pop_i,
  output logic                          valid_o,
  output bbd_pkg::bbd_job_t             job_o,
  output logic [bbd_pkg::QueueCntW-1:0] count_o
);

  localparam int unsigned AW = $clog2(bbd_pkg::QueueDepth);

  bbd_pkg::bbd_job_t                 mem_q [bbd_pkg::QueueDepth];
  logic [AW-1:0]                     wptr_q, rptr_q;
  logic [bbd_pkg::QueueCntW-1:0]     cnt_q;
  logic                              do_pop;

  assign valid_o = cnt_q != '0;
  assign do_pop  = pop_i && valid_o;
  assign job_o   = mem_q[rptr_q];
  assign count_o = cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + AW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + AW'(1);
      end
      cnt_q <= cnt_q + bbd_pkg::QueueCntW'(push_i) - bbd_pkg::QueueCntW'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= job_i;
    end
  end

endmodule

FILE: rtl/core/bbd_back.sv
// Back end: neighbour averages per Bayer phase and the output register.
`timescale 1ns / 1ps
module bbd_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  bbd_pkg::bbd_job_t job_i,
  output logic              pop_o,
  bbd_out_if.source         out_if
);

  localparam int unsigned PW = bbd_pkg::PixWidth;

  // floor(sum / cnt) for cnt 1..4; thirds through a reciprocal, exact below 2048
  function automatic logic [PW-1:0] mean(input logic [9:0] sum, input logic [2:0] cnt);
    logic [20:0] p;
    p = 21'(sum) * 21'd683;
    case (cnt)
      3'd1:    mean = sum[7:0];
      3'd2:    mean = sum[8:1];
      3'd3:    mean = p[18:11];
      3'd4:    mean = sum[9:2];
      default: mean = '0;
    endcase
  endfunction

  logic          ul, ur, dl, dr;
  logic [9:0]    hs, vs, os, ds;
  logic [2:0]    hc, vc, oc, dc;
  logic [PW-1:0] hm, vm, om, dm, ctr;
  logic [PW-1:0] r_d, g_d, b_d;

  assign ul = job_i.has_u && job_i.has_l;
  assign ur = job_i.has_u && job_i.has_r;
  assign dl = job_i.has_d && job_i.has_l;
  assign dr = job_i.has_d && job_i.has_r;

  always_comb begin
    hs = (job_i.has_l ? 10'(job_i.win[3]) : 10'd0) + (job_i.has_r ? 10'(job_i.win[5]) : 10'd0);
    vs = (job_i.has_u ? 10'(job_i.win[1]) : 10'd0) + (job_i.has_d ? 10'(job_i.win[7]) : 10'd0);
    os = hs + vs;
    ds = (ul ? 10'(job_i.win[0]) : 10'd0) + (ur ? 10'(job_i.win[2]) : 10'd0)
       + (dl ? 10'(job_i.win[6]) : 10'd0) + (dr ? 10'(job_i.win[8]) : 10'd0);
    hc = 3'(job_i.has_l) + 3'(job_i.has_r);
    vc = 3'(job_i.has_u) + 3'(job_i.has_d);
    oc = hc + vc;
    dc = 3'(ul) + 3'(ur) + 3'(dl) + 3'(dr);
    hm  = mean(hs, hc);
    vm  = mean(vs, vc);
    om  = mean(os, oc);
    dm  = mean(ds, dc);
    ctr = job_i.win[4];
    if (job_i.x_odd == job_i.y_odd) begin
      g_d = ctr;
      r_d = job_i.y_odd ? vm : hm;
      b_d = job_i.y_odd ? hm : vm;
    end else if (!job_i.y_odd) begin
      r_d = ctr;
      g_d = om;
      b_d = dm;
    end else begin
      b_d = ctr;
      g_d = om;
      r_d = dm;
    end
  end

  assign pop_o = q_valid_i && (!out_if.valid || out_if.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.valid <= 1'b0;
    end else if (!out_if.valid || out_if.ready) begin
      out_if.valid <= q_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_if.red_out      <= r_d;
      out_if.green_out    <= g_d;
      out_if.blue_out     <= b_d;
      out_if.end_of_row   <= job_i.eor;
      out_if.end_of_frame <= job_i.eof;
    end
  end

endmodule

FILE: rtl/core/bilinear_bayer_demosaic_core.sv
// Top level of the streaming bilinear Bayer demosaic block.
// Usage:
//   in_if carries raw Bayer samples in raster order (op = sample) and, after
//   the last row, flush ticks (op = flush) that drain the window; W+1 ticks
//   finish a frame. Early flush ticks are dropped; late samples act as ticks.
//   out_if gives one RGB pixel per position with end-of-row/end-of-frame.
//   The cfg port writes image_width (index 0) and image_height (index 1);
//   any write restarts the raster counters. Write only while idle.
// Timing:
//   Throughput is one item per clock while in_if.ready is high. A pixel
//   appears once the item W+1 positions later has been transferred: the
//   line-store RAM read is registered with the sample, then the window is
//   written into the queue and the averaging stage loads the output register.
// Reset and stall:
//   Reset clears the counters, the queue and the output valid and loads
//   640 x 480. Line stores are not cleared; unwritten entries only reach
//   window places above the top row, which never count.
//   When the receiver stalls, the output holds, the four-entry queue fills
//   and in_if.ready drops once no room is left for items in flight.
`timescale 1ns / 1ps
module bilinear_bayer_demosaic_core #(
  parameter int unsigned MaxWidth = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bbd_pkg::CfgWidth-1:0] cfg_data_i,
  bbd_in_if.sink                       in_if,
  bbd_out_if.source                    out_if
);

  logic                          push, pop, q_valid;
  bbd_pkg::bbd_job_t             job_in, job_out;
  logic [bbd_pkg::QueueCntW-1:0] q_count;

  bbd_front #(
    .MaxWidth (MaxWidth)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_if      (in_if),
    .q_count_i  (q_count),
    .push_o     (push),
    .job_o      (job_in)
  );

  bbd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .job_o   (job_out),
    .count_o (q_count)
  );

  bbd_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .job_i     (job_out),
    .pop_o     (pop),
    .out_if    (out_if)
  );

endmodule

FILE: rtl/core/bbd_checker.sv
// Port-level checks of the demosaic block and the bind that attaches them.
`timescale 1ns / 1ps
module bbd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic       eor,
  input logic       eof
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable({red, green, blue, eor, eof}))
    else $error("stalled output changed");

  // last pixel of the frame is also last of its row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && eof |-> eor)
    else $error("end_of_frame without end_of_row");

  // nothing is offered while reset is held
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("output valid during reset");

endmodule

bind bilinear_bayer_demosaic_core bbd_checker u_bbd_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (out_if.valid),
  .out_ready (out_if.ready),
  .red       (out_if.red_out),
  .green     (out_if.green_out),
  .blue      (out_if.blue_out),
  .eor       (out_if.end_of_row),
  .eof       (out_if.end_of_frame)
);

FILE: sim/bbd_demosaic_checker.sv
// Checker for the Bayer demosaic core: predicts each RGB pixel and compares it with the output.
`timescale 1ns / 1ps
module bbd_demosaic_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic                         cfg_idx_i,
  input  logic [bbd_pkg::CfgWidth-1:0] cfg_data_i,
  bbd_in_if                            raw_mon,
  bbd_out_if                           rgb_mon,
  output int                           mismatch_cnt_o,
  output int                           pixels_owed_o
);

  localparam int unsigned LineLen = 2048;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       eor;
    logic       eof;
  } rgb_pixel_t;

  logic [bbd_pkg::CfgWidth-1:0] width_reg, height_reg;
  logic [7:0] upper_line [LineLen];
  logic [7:0] middle_line [LineLen];
  logic [7:0] win [9];
  int unsigned in_col, in_row, out_col, out_row;
  rgb_pixel_t owed_pixels [$];

  function automatic logic [7:0] mean4(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                       logic [7:0] d, bit ea, bit eb, bit ec, bit ed);
    int unsigned sum, cnt;
    sum = (ea ? a : 0) + (eb ? b : 0) + (ec ? c : 0) + (ed ? d : 0);
    cnt = ea + eb + ec + ed;
    return (cnt != 0) ? 8'(sum / cnt) : 8'd0;
  endfunction

  task automatic clear_raster();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
  endtask

  // one accepted input item; may push one expected pixel
  task automatic demosaic_step(logic op, logic [7:0] raw);
    int unsigned w, h, c, x, y;
    logic [7:0] s, up, mid;
    bit ready, l, rt, u, d;
    rgb_pixel_t px;
    w = (width_reg < 2) ? 2 : ((width_reg > LineLen) ? LineLen : width_reg);
    h = (height_reg < 2) ? 2 : height_reg;
    if (in_row < h && op == bbd_pkg::OpFlush) return;
    s = (in_row < h) ? raw : 8'd0;
    c = in_col % LineLen;
    up = upper_line[c];
    mid = middle_line[c];
    upper_line[c] = mid;
    middle_line[c] = s;
    for (int k = 0; k < 3; k++) begin
      win[k*3] = win[k*3+1];
      win[k*3+1] = win[k*3+2];
    end
    win[2] = up;
    win[5] = mid;
    win[8] = s;
    ready = (in_row >= 2) || (in_row == 1 && in_col >= 1);
    in_col++;
    if (in_col >= w) begin
      in_col = 0;
      in_row++;
    end
    if (!ready) return;
    x = out_col;
    y = out_row;
    l = x > 0;
    rt = x + 1 < w;
    u = y > 0;
    d = y + 1 < h;
    if (((x + y) & 1) == 0) begin
      px.green = win[4];
      if ((y & 1) == 0) begin
        px.red  = mean4(win[3], win[5], 0, 0, l, rt, 0, 0);
        px.blue = mean4(win[1], win[7], 0, 0, u, d, 0, 0);
      end else begin
        px.blue = mean4(win[3], win[5], 0, 0, l, rt, 0, 0);
        px.red  = mean4(win[1], win[7], 0, 0, u, d, 0, 0);
      end
    end else begin
      px.green = mean4(win[3], win[5], win[1], win[7], l, rt, u, d);
      if ((y & 1) == 0) begin
        px.red  = win[4];
        px.blue = mean4(win[0], win[2], win[6], win[8], u && l, u && rt, d && l, d && rt);
      end else begin
        px.blue = win[4];
        px.red  = mean4(win[0], win[2], win[6], win[8], u && l, u && rt, d && l, d && rt);
      end
    end
    px.eor = (x == w - 1);
    px.eof = px.eor && (y == h - 1);
    owed_pixels.push_back(px);
    if (px.eof) begin
      clear_raster();
    end else begin
      out_col++;
      if (out_col >= w) begin
        out_col = 0;
        out_row++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rgb_pixel_t got, want;
    if (!rst_ni) begin
      width_reg = bbd_pkg::WidthReset;
      height_reg = bbd_pkg::HeightReset;
      for (int k = 0; k < 9; k++) win[k] = '0;
      clear_raster();
      owed_pixels.delete();
      mismatch_cnt_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == bbd_pkg::RegWidth) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        clear_raster();
      end
      if (raw_mon.valid && raw_mon.ready) demosaic_step(raw_mon.op, raw_mon.raw_sample);
      if (rgb_mon.valid && rgb_mon.ready) begin
        got = {rgb_mon.red_out, rgb_mon.green_out, rgb_mon.blue_out,
               rgb_mon.end_of_row, rgb_mon.end_of_frame};
        if (owed_pixels.size() == 0) begin
          $display("%0t: unexpected pixel r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                   $time, got.red, got.green, got.blue, got.eor, got.eof);
          mismatch_cnt_o++;
        end else begin
          want = owed_pixels.pop_front();
          if (got !== want) begin
            $display("%0t: pixel mismatch expected r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                     $time, want.red, want.green, want.blue, want.eor, want.eof);
            $display("%0t:                  actual r=%0d g=%0d b=%0d eor=%0b eof=%0b",
                     $time, got.red, got.green, got.blue, got.eor, got.eof);
            mismatch_cnt_o++;
          end
        end
      end
    end
    pixels_owed_o = owed_pixels.size();
  end

endmodule

FILE: sim/tb_top.sv
// Testbench top for the Bayer demosaic core: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_top;

  localparam int unsigned CycleLimit = 3000000;

  logic clk, rst_n;
  logic cfg_we, cfg_idx;
  logic [bbd_pkg::CfgWidth-1:0] cfg_data;
  int mismatch_cnt, pixels_owed;
  int unsigned cycles, items_sent, stall_left;
  bit no_gaps, no_stalls, rgb_took;

  bbd_in_if raw_ch ();
  bbd_out_if rgb_ch ();

  bilinear_bayer_demosaic_core dut (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .in_if(raw_ch.sink), .out_if(rgb_ch.source)
  );

  bbd_demosaic_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n), .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx),
    .cfg_data_i(cfg_data), .raw_mon(raw_ch), .rgb_mon(rgb_ch),
    .mismatch_cnt_o(mismatch_cnt), .pixels_owed_o(pixels_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    rgb_took <= rgb_ch.valid && rgb_ch.ready;
    if (cycles > CycleLimit) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver back-pressure, one stall draw per pixel transfer
  always @(negedge clk) begin
    if (rgb_took) stall_left = no_stalls ? 0 : $urandom_range(0, 6);
    if (stall_left > 0) begin
      rgb_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      rgb_ch.ready <= 1'b1;
    end
  end

  task automatic send_item(logic op, logic [7:0] raw);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      raw_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    raw_ch.valid <= 1'b1;
    raw_ch.op <= op;
    raw_ch.raw_sample <= raw;
    @(posedge clk);
    while (!raw_ch.ready) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic wait_idle();
    raw_ch.valid <= 1'b0;
    while (pixels_owed != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [bbd_pkg::CfgWidth-1:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // one frame at the given effective size; stop_at < w*h aborts it early
  task automatic run_frame(int unsigned w, int unsigned h, int unsigned stop_at);
    for (int unsigned i = 0; i < w * h && i < stop_at; i++) begin
      if ($urandom_range(0, 19) == 0) send_item(bbd_pkg::OpFlush, 8'($urandom));
      send_item(bbd_pkg::OpSample, (i < 4) ? (i[0] ? 8'hff : 8'h00) : 8'($urandom));
    end
    if (stop_at < w * h) return;
    for (int unsigned i = 0; i <= w; i++) begin
      // late samples drain like flush ticks
      if ($urandom_range(0, 3) == 0) send_item(bbd_pkg::OpSample, 8'($urandom));
      else send_item(bbd_pkg::OpFlush, 8'($urandom));
    end
  endtask

  task automatic sized_frame(logic [bbd_pkg::CfgWidth-1:0] wr,
                             logic [bbd_pkg::CfgWidth-1:0] hr,
                             int unsigned w, int unsigned h);
    wait_idle();
    write_reg(bbd_pkg::RegWidth, wr);
    write_reg(bbd_pkg::RegHeight, hr);
    run_frame(w, h, w * h);
  endtask

  initial begin
    int unsigned w, h;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = bbd_pkg::RegWidth;
    cfg_data = '0;
    raw_ch.valid = 1'b0;
    raw_ch.op = bbd_pkg::OpSample;
    raw_ch.raw_sample = '0;
    rgb_ch.ready = 1'b0;
    cycles = 0;
    items_sent = 0;
    stall_left = 0;
    no_gaps = 0;
    no_stalls = 0;
    rgb_took = 0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // directed: smallest frames, clamped geometry, back-to-back frames
    sized_frame(12'd2, 12'd2, 2, 2);
    run_frame(2, 2, 4);
    sized_frame(12'd1, 12'd0, 2, 2);
    sized_frame(12'd3, 12'd3, 3, 3);

    items_sent = 0;
    while (items_sent < 1250) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      no_stalls = ($urandom_range(0, 3) == 0);
      w = $urandom_range(2, 12);
      h = $urandom_range(2, 6);
      if ($urandom_range(0, 4) == 0) begin
        run_frame(w, h, w * h);  // new frame at the old size is not guaranteed; stay in sync
      end
      wait_idle();
      write_reg(bbd_pkg::RegWidth, 12'(w));
      write_reg(bbd_pkg::RegHeight, 12'(h));
      if ($urandom_range(0, 9) == 0) begin
        // abandoned frame, then a register write restarts the raster
        run_frame(w, h, $urandom_range(1, w * h - 1));
        wait_idle();
        write_reg(bbd_pkg::RegHeight, 12'(h));
      end
      run_frame(w, h, w * h);
      if ($urandom_range(0, 2) == 0) run_frame(w, h, w * h);
    end

    wait_idle();
    repeat (20) @(negedge clk);
    if (mismatch_cnt == 0 && pixels_owed == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/core/bbd_pkg.sv
rtl/core/bbd_stream_if.sv
rtl/core/bbd_ram.sv
rtl/core/bbd_front.sv
rtl/core/bbd_fifo.sv
rtl/core/bbd_back.sv
rtl/core/bilinear_bayer_demosaic_core.sv
rtl/core/bbd_checker.sv
sim/bbd_demosaic_checker.sv
sim/tb_top.sv
